### rtl/assert_macros.svh
// Assertion macros shared by the angle pipeline RTL.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VAD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
`define VAD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication failed");
`else
`define VAD_ASSERT(lbl, prop)
`define VAD_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

### rtl/vad_pkg.sv
// Shared constants, data types and the arctangent table for the angle pipeline.
// No dependencies.
`default_nettype none
package vad_pkg;
	// Width of the CORDIC x and y legs; ZW is the width of the angle accumulator.
	localparam int CW = 36;
	localparam int ZW = 33;
	localparam int SQRT_STEPS = 32;
	localparam int CORDIC_STEPS = 31;

	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 33'sd1686629713;
	localparam logic [31:0] DEG64_PER_RAD_Q20 = 32'd3845054675;
	localparam logic [13:0] MAX_ANGLE = 14'd11520;

	// Data handed from one square root cell to the next.
	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] root;
		logic signed [CW-1:0] xs;
		logic neg;
		logic zero;
	} sqrt_data_t;

	// Data handed from one CORDIC cell to the next.
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic neg;
		logic zero;
	} cordic_data_t;

	// atan(2^-i) in radians, Q2.30; small angles are 2^(30-i).
	function automatic logic signed [ZW-1:0] atan_step(input int idx);
		case (idx)
			0: atan_step = 33'sd843314856;
			1: atan_step = 33'sd497837829;
			2: atan_step = 33'sd263043836;
			3: atan_step = 33'sd133525158;
			4: atan_step = 33'sd67021686;
			5: atan_step = 33'sd33543515;
			6: atan_step = 33'sd16775850;
			7: atan_step = 33'sd8388437;
			8: atan_step = 33'sd4194282;
			9: atan_step = 33'sd2097149;
			10: atan_step = 33'sd1048575;
			default: atan_step = ZW'(1) << (30 - idx);
		endcase
	endfunction
endpackage
`default_nettype wire

### rtl/vad_sample_if.sv
// Input channel: one pair of three-axis samples per item.
// Depends on nothing.
`default_nettype none
interface vad_sample_if #(parameter int SAMPLE_BITS = 13);
	logic valid;
	logic ready;
	logic signed [SAMPLE_BITS-1:0] a_x;
	logic signed [SAMPLE_BITS-1:0] a_y;
	logic signed [SAMPLE_BITS-1:0] a_z;
	logic signed [SAMPLE_BITS-1:0] b_x;
	logic signed [SAMPLE_BITS-1:0] b_y;
	logic signed [SAMPLE_BITS-1:0] b_z;
	modport source(output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
	modport sink(input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface
`default_nettype wire

### rtl/vad_result_if.sv
// Output channel: one angle item per input item.
// Depends on nothing.
`default_nettype none
interface vad_result_if;
	logic valid;
	logic ready;
	logic [13:0] angle;
	logic valid_res;
	modport source(output valid, angle, valid_res, input ready);
	modport sink(input valid, angle, valid_res, output ready);
endinterface
`default_nettype wire

### rtl/vector_angle_degrees.sv
// Angle between two three-axis vectors, in 1/64 degree, one item per cycle unless the output stalls.
// Pipeline: five front stages, 32 square root cells, 31 CORDIC cells, three back.
// Throughput is one item per cycle unless the output stalls; each stage moves on when the next is empty or moving.
// Asynchronous active-low reset clears all valid flags; the pipeline is empty after reset.
// Depends on vad_pkg, vad_sample_if, vad_result_if, vad_sqrt_cell, vad_cordic_cell.
`default_nettype none
`include "assert_macros.svh"
module vector_angle_degrees import vad_pkg::*; #(
	parameter int SAMPLE_BITS = 13
) (
	input wire logic     clk,
	input wire logic     arst_n,
	vad_sample_if.sink   samples,
	vad_result_if.source result
);
	localparam int PW = 2 * SAMPLE_BITS;
	localparam int DW = PW + 1;
	localparam int QW = 4 * SAMPLE_BITS;

	function automatic logic [6:0] bit_len(input logic [QW-1:0] v);
		logic [6:0] n;
		n = '0;
		for (int i = 0; i < QW; i++) begin
			if (v[i]) n = 7'(i + 1);
		end
		return n;
	endfunction

	// Stage 1: the nine products.
	logic v_s1, rdy_s1;
	logic signed [PW-1:0] aa0_s1, aa1_s1, aa2_s1, bb0_s1, bb1_s1, bb2_s1;
	logic signed [PW-1:0] ab0_s1, ab1_s1, ab2_s1;
	// Stage 2: squared lengths and dot product.
	logic v_s2, rdy_s2;
	logic [PW-1:0] a2_s2, b2_s2, adot_s2;
	logic neg_s2, zero_s2;
	// Stage 3: length product and squared dot.
	logic v_s3, rdy_s3;
	logic [QW-1:0] prod2_s3, asq_s3;
	logic [PW-1:0] adot_s3;
	logic neg_s3, zero_s3;
	// Stage 4: squared cross length and scale.
	logic v_s4, rdy_s4;
	logic [QW-1:0] cross2_s4;
	logic [PW-1:0] adot_s4;
	logic [5:0] m_s4;
	logic neg_s4, zero_s4;
	// Stage 5: scaled legs.
	logic v_s5, rdy_s5;
	sqrt_data_t sq_s5;
	// Back stages.
	logic v_s6, rdy_s6, neg_s6, zero_s6;
	logic [31:0] theta_s6;
	logic v_s7, rdy_s7, zero_s7;
	logic [63:0] prod_s7;
	logic v_s8, rdy_s8, zero_s8;
	logic [13:0] angle_s8;

	// Links between the square root cells and between the CORDIC cells.
	logic         sv [0:SQRT_STEPS];
	logic         sr [0:SQRT_STEPS];
	sqrt_data_t   sd [0:SQRT_STEPS];
	logic         cv [0:CORDIC_STEPS];
	logic         cr [0:CORDIC_STEPS];
	cordic_data_t cd [0:CORDIC_STEPS];

	logic signed [DW-1:0] dot_c;
	logic [6:0] len_c;
	logic signed [ZW-1:0] zc;
	logic [63:0] rnd_c;
	logic [13:0] deg_c;

	assign rdy_s8 = !v_s8 || result.ready;
	assign rdy_s7 = !v_s7 || rdy_s8;
	assign rdy_s6 = !v_s6 || rdy_s7;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign samples.ready = rdy_s1;

	// Valid flags of the front and back stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= samples.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= cv[CORDIC_STEPS];
			if (rdy_s7) v_s7 <= v_s6;
			if (rdy_s8) v_s8 <= v_s7;
		end
	end

	// Front-end arithmetic.
	always_comb begin
		dot_c = DW'(ab0_s1) + DW'(ab1_s1) + DW'(ab2_s1);
		len_c = bit_len(prod2_s3);
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && samples.valid) begin
			aa0_s1 <= samples.a_x * samples.a_x;
			aa1_s1 <= samples.a_y * samples.a_y;
			aa2_s1 <= samples.a_z * samples.a_z;
			bb0_s1 <= samples.b_x * samples.b_x;
			bb1_s1 <= samples.b_y * samples.b_y;
			bb2_s1 <= samples.b_z * samples.b_z;
			ab0_s1 <= samples.a_x * samples.b_x;
			ab1_s1 <= samples.a_y * samples.b_y;
			ab2_s1 <= samples.a_z * samples.b_z;
		end
		if (rdy_s2 && v_s1) begin
			a2_s2 <= $unsigned(aa0_s1) + $unsigned(aa1_s1) + $unsigned(aa2_s1);
			b2_s2 <= $unsigned(bb0_s1) + $unsigned(bb1_s1) + $unsigned(bb2_s1);
			zero_s2 <= ((aa0_s1 | aa1_s1 | aa2_s1) == '0) || ((bb0_s1 | bb1_s1 | bb2_s1) == '0);
			neg_s2 <= dot_c[DW-1];
			adot_s2 <= dot_c[DW-1] ? PW'(-dot_c) : PW'(dot_c);
		end
		if (rdy_s3 && v_s2) begin
			prod2_s3 <= QW'(a2_s2) * QW'(b2_s2);
			asq_s3 <= QW'(adot_s2) * QW'(adot_s2);
			adot_s3 <= adot_s2;
			neg_s3 <= neg_s2;
			zero_s3 <= zero_s2;
		end
		if (rdy_s4 && v_s3) begin
			cross2_s4 <= prod2_s3 - asq_s3;
			m_s4 <= (len_c < 7'd62) ? 6'((7'd62 - len_c) >> 1) : 6'd0;
			adot_s4 <= adot_s3;
			neg_s4 <= neg_s3;
			zero_s4 <= zero_s3;
		end
		if (rdy_s5 && v_s4) begin
			sq_s5.rem <= 64'(cross2_s4) << {m_s4, 1'b0};
			sq_s5.root <= '0;
			sq_s5.xs <= CW'(64'(adot_s4) << m_s4);
			sq_s5.neg <= neg_s4;
			sq_s5.zero <= zero_s4;
		end
	end

	// Square root chain, one result bit per cell.
	assign sv[0] = v_s5;
	assign sd[0] = sq_s5;
	assign rdy_s5 = sr[0];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		vad_sqrt_cell #(.STEP(k)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(sv[k]), .in_ready(sr[k]), .in_data(sd[k]),
			.out_valid(sv[k+1]), .out_ready(sr[k+1]), .out_data(sd[k+1])
		);
	end

	// CORDIC chain on (scaled |dot|, |cross|).
	assign cv[0] = sv[SQRT_STEPS];
	assign sr[SQRT_STEPS] = cr[0];
	assign cd[0].x = sd[SQRT_STEPS].xs;
	assign cd[0].y = $signed(sd[SQRT_STEPS].root[CW-1:0]);
	assign cd[0].z = '0;
	assign cd[0].neg = sd[SQRT_STEPS].neg;
	assign cd[0].zero = sd[SQRT_STEPS].zero;
	assign cr[CORDIC_STEPS] = rdy_s6;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		vad_cordic_cell #(.IDX(i)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(cv[i]), .in_ready(cr[i]), .in_data(cd[i]),
			.out_valid(cv[i+1]), .out_ready(cr[i+1]), .out_data(cd[i+1])
		);
	end

	// Clamp to a quarter turn, unfold obtuse angles, scale, round and limit to MAX_ANGLE.
	always_comb begin
		zc = cd[CORDIC_STEPS].z;
		if (zc[ZW-1]) begin
			zc = '0;
		end else if (zc > HALF_PI_Q30) begin
			zc = HALF_PI_Q30;
		end
		rnd_c = prod_s7 + (64'd1 << 50 >> 1);
		deg_c = rnd_c[63:50];
		if (deg_c > MAX_ANGLE) deg_c = MAX_ANGLE;
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && cv[CORDIC_STEPS]) begin
			theta_s6 <= cd[CORDIC_STEPS].neg ? PI_Q30 - 32'(zc) : 32'(zc);
			neg_s6 <= cd[CORDIC_STEPS].neg;
			zero_s6 <= cd[CORDIC_STEPS].zero;
		end
		if (rdy_s7 && v_s6) begin
			prod_s7 <= 64'(theta_s6) * 64'(DEG64_PER_RAD_Q20);
			zero_s7 <= zero_s6;
		end
		if (rdy_s8 && v_s7) begin
			angle_s8 <= zero_s7 ? 14'd0 : deg_c;
			zero_s8 <= zero_s7;
		end
	end

	assign result.valid = v_s8;
	assign result.angle = angle_s8;
	assign result.valid_res = !zero_s8;

	`VAD_ASSERT_IMP(a_angle_range, v_s8, angle_s8 <= MAX_ANGLE)
	`VAD_ASSERT_IMP(a_zero_angle, v_s8 && zero_s8, angle_s8 == 14'd0)
	`VAD_ASSERT_IMP(a_theta_range, v_s6, theta_s6 <= PI_Q30)
	`VAD_ASSERT_IMP(a_obtuse_half, v_s6 && neg_s6, theta_s6 >= 32'(HALF_PI_Q30))
	`VAD_ASSERT_IMP(a_take_when_empty, !v_s1, samples.ready)
endmodule
`default_nettype wire

### rtl/vad_sqrt_cell.sv
// One bit of the digit-by-digit integer square root, as a pipeline cell.
// Depends on vad_pkg.
`default_nettype none
module vad_sqrt_cell import vad_pkg::*; #(
	parameter int STEP = 0
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire sqrt_data_t in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output sqrt_data_t      out_data
);
	localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

	logic        v_q;
	sqrt_data_t  d_q;
	sqrt_data_t  nxt;
	logic [63:0] trial;

	assign in_ready = !v_q || out_ready;
	assign out_valid = v_q;
	assign out_data = d_q;

	// Try subtracting root plus the current bit from the remainder.
	always_comb begin
		nxt = in_data;
		trial = in_data.root + BIT;
		if (in_data.rem >= trial) begin
			nxt.rem = in_data.rem - trial;
			nxt.root = (in_data.root >> 1) + BIT;
		end else begin
			nxt.root = in_data.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_q <= nxt;
		end
	end
endmodule
`default_nettype wire

### rtl/vad_cordic_cell.sv
// One vectoring-mode CORDIC rotation, as a pipeline cell.
// Depends on vad_pkg.
`default_nettype none
module vad_cordic_cell import vad_pkg::*; #(
	parameter int IDX = 0
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire cordic_data_t in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output cordic_data_t      out_data
);
	localparam logic signed [ZW-1:0] STEP_ANGLE = atan_step(IDX);

	logic                 v_q;
	cordic_data_t         d_q;
	cordic_data_t         nxt;
	logic signed [CW-1:0] xi;
	logic signed [CW-1:0] yi;
	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;

	assign in_ready = !v_q || out_ready;
	assign out_valid = v_q;
	assign out_data = d_q;

	// Rotate toward the x axis; the sign of y picks the direction.
	always_comb begin
		xi = in_data.x;
		yi = in_data.y;
		dx = yi >>> IDX;
		dy = xi >>> IDX;
		nxt = in_data;
		if (!yi[CW-1] && (yi != '0)) begin
			nxt.x = xi + dx;
			nxt.y = yi - dy;
			nxt.z = in_data.z + STEP_ANGLE;
		end else begin
			nxt.x = xi - dx;
			nxt.y = yi + dy;
			nxt.z = in_data.z - STEP_ANGLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_q <= nxt;
		end
	end
endmodule
`default_nettype wire
